[rtl/qpl_pkg.sv]
// ----------------------------------------------------------------------------
// qpl_pkg: shared types and constants for the patch-to-lab-frame pipeline
// Holds the transfer structs of both channels, the rotation matrix beat that
// travels between the matrix unit and the top level, and the datapath widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qpl_pkg;

  // Field widths of the channels.
  localparam int QuatW = 16;  // Q2.14 quaternion component
  localparam int FixW  = 32;  // Q16.16 coordinate

  // Rotation matrix entry widths.
  localparam int ProdW    = 2 * QuatW;        // one quaternion product, Q4.28
  localparam int RawW     = ProdW + 2;        // entry before rounding, Q6.28
  localparam int RndEntSh = 4;                // Q6.28 to Q.24
  localparam int EntW     = RawW - RndEntSh;  // rounded entry, Q.24

  // Matrix-vector widths.
  localparam int MulW  = EntW + FixW;   // entry times offset, 40 fraction bits
  localparam int AccW  = MulW + 2;      // sum of three products
  localparam int AccSh = 24;            // 40 fraction bits down to 16
  localparam int CrdW  = AccW - AccSh;  // rounded rotated offset, Q.16
  localparam int SumW  = CrdW + 1;      // centre plus rotated offset

  // Number of register stages between an input transfer and its result strobe.
  localparam int PipeDepth = 5;

  typedef logic signed [EntW-1:0] ent_t;
  typedef ent_t [2:0][2:0] mat_t;

  typedef struct packed {
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [FixW-1:0]  centre_x;
    logic signed [FixW-1:0]  centre_y;
    logic signed [FixW-1:0]  centre_z;
    logic signed [FixW-1:0]  offset_x;
    logic signed [FixW-1:0]  offset_y;
    logic signed [FixW-1:0]  offset_z;
    logic                    last_patch;
  } in_t;

  typedef struct packed {
    logic signed [FixW-1:0] patch_x;
    logic signed [FixW-1:0] patch_y;
    logic signed [FixW-1:0] patch_z;
    logic                   last_patch_out;
  } out_t;

  // One beat out of the matrix unit: valid flag and the rounded matrix.
  typedef struct packed {
    logic vld;
    mat_t mat;
  } rot_t;

endpackage

[rtl/qpl_rot_matrix.sv]
// ----------------------------------------------------------------------------
// qpl_rot_matrix: quaternion to rotation matrix, two register stages
// Stage one registers the ten quaternion products. Stage two combines them
// into the nine matrix entries and rounds each one to 24 fraction bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpl_rot_matrix (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic signed [qpl_pkg::QuatW-1:0]  qw,
  input  logic signed [qpl_pkg::QuatW-1:0]  qx,
  input  logic signed [qpl_pkg::QuatW-1:0]  qy,
  input  logic signed [qpl_pkg::QuatW-1:0]  qz,
  output qpl_pkg::rot_t                     rot
);

  localparam logic signed [qpl_pkg::RawW-1:0] RndHalf =
    qpl_pkg::RawW'(1 << (qpl_pkg::RndEntSh - 1));

  // Stage one: products.
  logic                              s1_vld_r;
  logic signed [qpl_pkg::ProdW-1:0]  ww_r, xx_r, yy_r, zz_r;
  logic signed [qpl_pkg::ProdW-1:0]  xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  // Stage two: rounded entries.
  logic           s2_vld_r;
  qpl_pkg::mat_t  mat_r;

  logic signed [qpl_pkg::RawW-1:0] ww_e, xx_e, yy_e, zz_e;
  logic signed [qpl_pkg::RawW-1:0] xy_e, wz_e, xz_e, wy_e, yz_e, wx_e;
  logic signed [qpl_pkg::RawW-1:0] raw [3][3];
  logic signed [qpl_pkg::RawW-1:0] rnd [3][3];
  qpl_pkg::mat_t                   mat_nxt;

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Quaternion products, exact in Q4.28.
  always_ff @(posedge clk) begin
    ww_r <= qw * qw;
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    wz_r <= qw * qz;
    xz_r <= qx * qz;
    wy_r <= qw * qy;
    yz_r <= qy * qz;
    wx_r <= qw * qx;
  end

  // Sign-extend the products to the entry width.
  assign ww_e = qpl_pkg::RawW'(ww_r);
  assign xx_e = qpl_pkg::RawW'(xx_r);
  assign yy_e = qpl_pkg::RawW'(yy_r);
  assign zz_e = qpl_pkg::RawW'(zz_r);
  assign xy_e = qpl_pkg::RawW'(xy_r);
  assign wz_e = qpl_pkg::RawW'(wz_r);
  assign xz_e = qpl_pkg::RawW'(xz_r);
  assign wy_e = qpl_pkg::RawW'(wy_r);
  assign yz_e = qpl_pkg::RawW'(yz_r);
  assign wx_e = qpl_pkg::RawW'(wx_r);

  // Matrix entries; the off-diagonal terms carry the factor of two as a shift.
  assign raw[0][0] = ww_e + xx_e - yy_e - zz_e;
  assign raw[0][1] = (xy_e + wz_e) <<< 1;
  assign raw[0][2] = (xz_e - wy_e) <<< 1;
  assign raw[1][0] = (xy_e - wz_e) <<< 1;
  assign raw[1][1] = ww_e - xx_e + yy_e - zz_e;
  assign raw[1][2] = (yz_e + wx_e) <<< 1;
  assign raw[2][0] = (xz_e + wy_e) <<< 1;
  assign raw[2][1] = (yz_e - wx_e) <<< 1;
  assign raw[2][2] = ww_e - xx_e - yy_e + zz_e;

  // Round half up and drop the low fraction bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rnd[i][j]     = raw[i][j] + RndHalf;
        mat_nxt[i][j] = rnd[i][j][qpl_pkg::RawW-1:qpl_pkg::RndEntSh];
      end
    end
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign rot.vld = s2_vld_r;
  assign rot.mat = mat_r;

endmodule

[rtl/quaternion_patch_to_lab_frame.sv]
// ----------------------------------------------------------------------------
// quaternion_patch_to_lab_frame: lab-frame position of a rigid-particle patch
// Rotates the body-frame offset by the transpose of the quaternion's rotation
// matrix, adds the particle centre and saturates each coordinate to 32 bits.
// ----------------------------------------------------------------------------
//  channel  ports                     handshake
//  input    start, busy, in_item      transfer when start and not busy
//  result   out_valid, out_item       one-cycle strobe, no back-pressure
//
//  One item may enter every cycle; each result passes through these register
//  stages in order: quaternion products, matrix entries, entry-times-offset
//  products, three-term sum with rounding, centre add with saturation.
//  Reset clears every valid bit; busy is high while reset is applied and in
//  the first cycle after its release, and for nothing else. The pipeline
//  never stalls, since results cannot be held off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quaternion_patch_to_lab_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  qpl_pkg::in_t   in_item,
  output logic           out_valid,
  output qpl_pkg::out_t  out_item
);

  localparam logic signed [qpl_pkg::AccW-1:0] AccHalf =
    qpl_pkg::AccW'(64'sd1 <<< (qpl_pkg::AccSh - 1));
  localparam logic signed [qpl_pkg::FixW-1:0] SatMax = {1'b0, {(qpl_pkg::FixW-1){1'b1}}};
  localparam logic signed [qpl_pkg::FixW-1:0] SatMin = {1'b1, {(qpl_pkg::FixW-1){1'b0}}};

  logic           busy_r;
  logic           in_xfer;
  qpl_pkg::rot_t  rot;

  // Side pipelines that keep offset, centre and flag aligned with the matrix.
  logic signed [qpl_pkg::FixW-1:0] ofs_pipe_r [2][3];
  logic signed [qpl_pkg::FixW-1:0] ctr_pipe_r [4][3];
  logic [qpl_pkg::PipeDepth-1:0]   last_pipe_r;

  // Stage three and four registers.
  logic                            s3_vld_r, s4_vld_r;
  logic signed [qpl_pkg::MulW-1:0] prod_r [3][3];
  logic signed [qpl_pkg::CrdW-1:0] crd_r [3];

  // Output register.
  logic                            out_valid_r;
  logic signed [qpl_pkg::FixW-1:0] patch_r [3];

  logic signed [qpl_pkg::AccW-1:0] acc [3];
  logic signed [qpl_pkg::CrdW-1:0] crd_nxt [3];
  logic signed [qpl_pkg::SumW-1:0] sum [3];
  logic signed [qpl_pkg::FixW-1:0] patch_nxt [3];

  // Busy only covers reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy    = busy_r;
  assign in_xfer = start && !busy_r;

  // Rotation matrix from the quaternion, two stages.
  qpl_rot_matrix u_rot_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (in_xfer),
    .qw     (in_item.quat_w),
    .qx     (in_item.quat_x),
    .qy     (in_item.quat_y),
    .qz     (in_item.quat_z),
    .rot    (rot)
  );

  // Side pipelines shift every cycle.
  always_ff @(posedge clk) begin
    ofs_pipe_r[0][0] <= in_item.offset_x;
    ofs_pipe_r[0][1] <= in_item.offset_y;
    ofs_pipe_r[0][2] <= in_item.offset_z;
    ofs_pipe_r[1]    <= ofs_pipe_r[0];
    ctr_pipe_r[0][0] <= in_item.centre_x;
    ctr_pipe_r[0][1] <= in_item.centre_y;
    ctr_pipe_r[0][2] <= in_item.centre_z;
    for (int k = 1; k < 4; k++) begin
      ctr_pipe_r[k] <= ctr_pipe_r[k-1];
    end
    last_pipe_r <= {last_pipe_r[qpl_pkg::PipeDepth-2:0], in_item.last_patch};
  end

  // Valid bits of the later stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s3_vld_r    <= rot.vld;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  // Stage three: coordinate i takes column i of the matrix against the offset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_r[i][j] <= $signed(rot.mat[j][i]) * ofs_pipe_r[1][j];
      end
    end
  end

  // Stage four: three-term sum, rounded to 16 fraction bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = qpl_pkg::AccW'(prod_r[i][0]) + qpl_pkg::AccW'(prod_r[i][1])
             + qpl_pkg::AccW'(prod_r[i][2]) + AccHalf;
      crd_nxt[i] = acc[i][qpl_pkg::AccW-1:qpl_pkg::AccSh];
    end
  end

  always_ff @(posedge clk) begin
    crd_r <= crd_nxt;
  end

  // Stage five: add the centre and clamp to the 32-bit range.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = qpl_pkg::SumW'(crd_r[i]) + qpl_pkg::SumW'(ctr_pipe_r[3][i]);
      if (sum[i][qpl_pkg::SumW-1:qpl_pkg::FixW-1] == '0 ||
          sum[i][qpl_pkg::SumW-1:qpl_pkg::FixW-1] == '1) begin
        patch_nxt[i] = sum[i][qpl_pkg::FixW-1:0];
      end else if (sum[i][qpl_pkg::SumW-1]) begin
        patch_nxt[i] = SatMin;
      end else begin
        patch_nxt[i] = SatMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    patch_r <= patch_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_item.patch_x        = patch_r[0];
  assign out_item.patch_y        = patch_r[1];
  assign out_item.patch_z        = patch_r[2];
  assign out_item.last_patch_out = last_pipe_r[qpl_pkg::PipeDepth-1];

  // Every input transfer gives a result strobe at the end of the pipeline.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##5 out_valid)
    else $error("result strobe missing after input transfer");

  // No result strobe without a matching input transfer.
  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |-> ##5 !out_valid)
    else $error("result strobe without input transfer");

  // Busy is high only during reset and the first cycle after its release.
  a_busy_reset_only : assert property (@(posedge clk)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  // The flag stays aligned with its coordinates.
  a_flag_align : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.last_patch_out == $past(in_item.last_patch, 5))
    else $error("last-patch flag out of step with its result");

endmodule
